[hdl/cfbu_pkg.sv]
// shared types, codes and helper functions for the control flow branch unit
`timescale 1ns / 1ps

package cfbu_pkg;

    // instruction codes
    localparam logic [3:0] CMD_BCC  = 4'd0;
    localparam logic [3:0] CMD_BRA  = 4'd1;
    localparam logic [3:0] CMD_BSR  = 4'd2;
    localparam logic [3:0] CMD_DBCC = 4'd3;
    localparam logic [3:0] CMD_JMP  = 4'd4;
    localparam logic [3:0] CMD_JSR  = 4'd5;
    localparam logic [3:0] CMD_NOP  = 4'd6;
    localparam logic [3:0] CMD_RTR  = 4'd7;
    localparam logic [3:0] CMD_RTS  = 4'd8;

    // condition codes
    localparam logic [3:0] CC_T  = 4'd0;
    localparam logic [3:0] CC_F  = 4'd1;
    localparam logic [3:0] CC_HI = 4'd2;
    localparam logic [3:0] CC_LS = 4'd3;
    localparam logic [3:0] CC_CC = 4'd4;
    localparam logic [3:0] CC_CS = 4'd5;
    localparam logic [3:0] CC_NE = 4'd6;
    localparam logic [3:0] CC_EQ = 4'd7;
    localparam logic [3:0] CC_VC = 4'd8;
    localparam logic [3:0] CC_VS = 4'd9;
    localparam logic [3:0] CC_PL = 4'd10;
    localparam logic [3:0] CC_MI = 4'd11;
    localparam logic [3:0] CC_GE = 4'd12;
    localparam logic [3:0] CC_LT = 4'd13;
    localparam logic [3:0] CC_GT = 4'd14;
    localparam logic [3:0] CC_LE = 4'd15;

    // cycle charges
    localparam logic [4:0] CYC_NONE       = 5'd0;
    localparam logic [4:0] CYC_NOP        = 5'd4;
    localparam logic [4:0] CYC_BCC_BYTE   = 5'd8;
    localparam logic [4:0] CYC_BRANCH     = 5'd10;
    localparam logic [4:0] CYC_BCC_WORD   = 5'd12;
    localparam logic [4:0] CYC_DB_TRUE    = 5'd12;
    localparam logic [4:0] CYC_DB_EXPIRED = 5'd14;
    localparam logic [4:0] CYC_RTS        = 5'd16;
    localparam logic [4:0] CYC_BSR        = 5'd18;
    localparam logic [4:0] CYC_RTR        = 5'd20;

    // program counter source select
    localparam logic [1:0] PC_NEXT = 2'd0;
    localparam logic [1:0] PC_REL  = 2'd1;
    localparam logic [1:0] PC_JUMP = 2'd2;
    localparam logic [1:0] PC_POP  = 2'd3;

    // stack pointer adjustments
    localparam logic [31:0] SP_KEEP = 32'h0000_0000;
    localparam logic [31:0] SP_PUSH = 32'hFFFF_FFFC;
    localparam logic [31:0] SP_RTS  = 32'h0000_0004;
    localparam logic [31:0] SP_RTR  = 32'h0000_0006;

    localparam logic [31:0] OPCODE_BYTES = 32'd2;

    // control decided at decode, carried to the output stage
    typedef struct packed {
        logic       taken;
        logic       mem_write;
        logic       counter_write;
        logic       ccr_write;
        logic [4:0] cycles;
        logic [1:0] pc_sel;
    } ctl_t;

    // decode stage payload
    typedef struct packed {
        ctl_t        ctl;
        logic [31:0] base;
        logic [31:0] disp;
        logic [31:0] jump_target;
        logic [31:0] next_pc;
        logic [31:0] stack_ptr;
        logic [31:0] sp_offset;
        logic [15:0] counter;
        logic [4:0]  popped_ccr;
        logic [31:0] popped_long;
    } dec_t;

    // address stage payload
    typedef struct packed {
        ctl_t        ctl;
        logic [31:0] rel_target;
        logic [31:0] jump_target;
        logic [31:0] next_pc;
        logic [31:0] new_sp;
        logic [15:0] new_counter;
        logic [4:0]  popped_ccr;
        logic [31:0] popped_long;
    } addr_t;

    // standard condition table on X N Z V C
    function automatic logic cond_true(input logic [3:0] code, input logic [4:0] flags);
        logic c;
        logic v;
        logic z;
        logic n;
        logic res;
        c = flags[0];
        v = flags[1];
        z = flags[2];
        n = flags[3];
        case (code)
            CC_T:    res = 1'b1;
            CC_F:    res = 1'b0;
            CC_HI:   res = !c && !z;
            CC_LS:   res = c || z;
            CC_CC:   res = !c;
            CC_CS:   res = c;
            CC_NE:   res = !z;
            CC_EQ:   res = z;
            CC_VC:   res = !v;
            CC_VS:   res = v;
            CC_PL:   res = !n;
            CC_MI:   res = n;
            CC_GE:   res = (n == v);
            CC_LT:   res = (n != v);
            CC_GT:   res = !z && (n == v);
            default: res = z || (n != v);
        endcase
        return res;
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

endpackage

[hdl/cfbu_decode.sv]
// stage one: condition check, control decode, displacement and base setup
`timescale 1ns / 1ps

module cfbu_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [3:0]          cmd,
    input  logic [3:0]          cond_code,
    input  logic [4:0]          ccr_flags,
    input  logic [31:0]         instr_addr,
    input  logic [31:0]         next_pc,
    input  logic [31:0]         operand,
    input  logic                short_disp,
    input  logic                abs_short,
    input  logic [15:0]         counter,
    input  logic [31:0]         stack_ptr,
    input  logic [15:0]         popped_word,
    input  logic [31:0]         popped_long,
    output logic                dec_valid,
    output cfbu_pkg::dec_t      dec_data
);

    logic            valid_reg;
    cfbu_pkg::dec_t  data_reg;
    cfbu_pkg::dec_t  data_next;
    logic            cond_ok;
    logic            cnt_zero;
    logic            byte_disp;

    assign cond_ok   = cfbu_pkg::cond_true(cond_code, ccr_flags);
    assign cnt_zero  = (counter == 16'd0);
    // dbcc always takes a word displacement
    assign byte_disp = short_disp && (cmd != cfbu_pkg::CMD_DBCC);

    // decode control and operands
    always_comb
    begin
        data_next.ctl.taken         = 1'b0;
        data_next.ctl.mem_write     = 1'b0;
        data_next.ctl.counter_write = 1'b0;
        data_next.ctl.ccr_write     = 1'b0;
        data_next.ctl.cycles        = cfbu_pkg::CYC_NONE;
        data_next.ctl.pc_sel        = cfbu_pkg::PC_NEXT;
        data_next.sp_offset         = cfbu_pkg::SP_KEEP;
        data_next.base              = instr_addr + cfbu_pkg::OPCODE_BYTES;
        data_next.disp              = byte_disp ? cfbu_pkg::sext8(operand[7:0])
                                                : cfbu_pkg::sext16(operand[15:0]);
        data_next.jump_target       = operand;
        data_next.next_pc           = next_pc;
        data_next.stack_ptr         = stack_ptr;
        data_next.counter           = counter;
        data_next.popped_ccr        = popped_word[4:0];
        data_next.popped_long       = popped_long;
        case (cmd)
            cfbu_pkg::CMD_BCC:
            begin
                if (cond_ok)
                begin
                    data_next.ctl.taken  = 1'b1;
                    data_next.ctl.pc_sel = cfbu_pkg::PC_REL;
                    data_next.ctl.cycles = cfbu_pkg::CYC_BRANCH;
                end
                else
                begin
                    data_next.ctl.cycles = short_disp ? cfbu_pkg::CYC_BCC_BYTE
                                                      : cfbu_pkg::CYC_BCC_WORD;
                end
            end
            cfbu_pkg::CMD_BRA:
            begin
                data_next.ctl.taken  = 1'b1;
                data_next.ctl.pc_sel = cfbu_pkg::PC_REL;
                data_next.ctl.cycles = cfbu_pkg::CYC_BRANCH;
            end
            cfbu_pkg::CMD_BSR:
            begin
                data_next.ctl.taken     = 1'b1;
                data_next.ctl.mem_write = 1'b1;
                data_next.ctl.pc_sel    = cfbu_pkg::PC_REL;
                data_next.ctl.cycles    = cfbu_pkg::CYC_BSR;
                data_next.sp_offset     = cfbu_pkg::SP_PUSH;
            end
            cfbu_pkg::CMD_DBCC:
            begin
                if (cond_ok)
                begin
                    data_next.ctl.cycles = cfbu_pkg::CYC_DB_TRUE;
                end
                else
                begin
                    data_next.ctl.counter_write = 1'b1;
                    if (!cnt_zero)
                    begin
                        data_next.ctl.taken  = 1'b1;
                        data_next.ctl.pc_sel = cfbu_pkg::PC_REL;
                        data_next.ctl.cycles = cfbu_pkg::CYC_BRANCH;
                    end
                    else
                    begin
                        data_next.ctl.cycles = cfbu_pkg::CYC_DB_EXPIRED;
                    end
                end
            end
            cfbu_pkg::CMD_JMP:
            begin
                data_next.ctl.taken  = 1'b1;
                data_next.ctl.pc_sel = cfbu_pkg::PC_JUMP;
            end
            cfbu_pkg::CMD_JSR:
            begin
                data_next.ctl.taken     = 1'b1;
                data_next.ctl.mem_write = 1'b1;
                data_next.ctl.pc_sel    = cfbu_pkg::PC_JUMP;
                data_next.sp_offset     = cfbu_pkg::SP_PUSH;
                if (abs_short)
                begin
                    data_next.jump_target = cfbu_pkg::sext16(operand[15:0]);
                end
            end
            cfbu_pkg::CMD_NOP:
            begin
                data_next.ctl.cycles = cfbu_pkg::CYC_NOP;
            end
            cfbu_pkg::CMD_RTR:
            begin
                data_next.ctl.taken     = 1'b1;
                data_next.ctl.ccr_write = 1'b1;
                data_next.ctl.pc_sel    = cfbu_pkg::PC_POP;
                data_next.ctl.cycles    = cfbu_pkg::CYC_RTR;
                data_next.sp_offset     = cfbu_pkg::SP_RTR;
            end
            cfbu_pkg::CMD_RTS:
            begin
                data_next.ctl.taken  = 1'b1;
                data_next.ctl.pc_sel = cfbu_pkg::PC_POP;
                data_next.ctl.cycles = cfbu_pkg::CYC_RTS;
                data_next.sp_offset  = cfbu_pkg::SP_RTS;
            end
            default:
            begin
                data_next.ctl.taken = 1'b0;
            end
        endcase
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dec_valid = valid_reg;
    assign dec_data  = data_reg;

endmodule

[hdl/cfbu_addr.sv]
// stage two: branch target, stack pointer and counter arithmetic
`timescale 1ns / 1ps

module cfbu_addr
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                dec_valid,
    input  cfbu_pkg::dec_t      dec_data,
    output logic                addr_valid,
    output cfbu_pkg::addr_t     addr_data
);

    logic             valid_reg;
    cfbu_pkg::addr_t  data_reg;
    cfbu_pkg::addr_t  data_next;

    // adders
    always_comb
    begin
        data_next.ctl         = dec_data.ctl;
        data_next.rel_target  = dec_data.base + dec_data.disp;
        data_next.jump_target = dec_data.jump_target;
        data_next.next_pc     = dec_data.next_pc;
        data_next.new_sp      = dec_data.stack_ptr + dec_data.sp_offset;
        data_next.new_counter = dec_data.counter - 16'd1;
        data_next.popped_ccr  = dec_data.popped_ccr;
        data_next.popped_long = dec_data.popped_long;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= dec_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (dec_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign addr_valid = valid_reg;
    assign addr_data  = data_reg;

endmodule

[hdl/cfbu_output.sv]
// stage three: result selection, field masking and output registers
`timescale 1ns / 1ps

module cfbu_output
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                addr_valid,
    input  cfbu_pkg::addr_t     addr_data,
    output logic                done,
    output logic [31:0]         new_pc,
    output logic [31:0]         new_sp,
    output logic                mem_write,
    output logic [31:0]         write_addr,
    output logic [31:0]         write_data,
    output logic [15:0]         new_counter,
    output logic                counter_write,
    output logic [4:0]          new_ccr,
    output logic                ccr_write,
    output logic                taken,
    output logic [4:0]          cycles
);

    logic        done_reg;
    logic [31:0] pc_reg;
    logic [31:0] pc_next;
    logic [31:0] sp_reg;
    logic        mw_reg;
    logic [31:0] waddr_reg;
    logic [31:0] wdata_reg;
    logic [15:0] cnt_reg;
    logic        cw_reg;
    logic [4:0]  ccr_reg;
    logic        crw_reg;
    logic        taken_reg;
    logic [4:0]  cycles_reg;

    // program counter source
    always_comb
    begin
        case (addr_data.ctl.pc_sel)
            cfbu_pkg::PC_REL:  pc_next = addr_data.rel_target;
            cfbu_pkg::PC_JUMP: pc_next = addr_data.jump_target;
            cfbu_pkg::PC_POP:  pc_next = addr_data.popped_long;
            default:           pc_next = addr_data.next_pc;
        endcase
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= addr_valid;
        end
    end

    // result payload, unused write, counter and ccr fields forced to zero
    always_ff @(posedge clk)
    begin
        if (addr_valid)
        begin
            pc_reg     <= pc_next;
            sp_reg     <= addr_data.new_sp;
            mw_reg     <= addr_data.ctl.mem_write;
            waddr_reg  <= addr_data.ctl.mem_write ? addr_data.new_sp : 32'd0;
            wdata_reg  <= addr_data.ctl.mem_write ? addr_data.next_pc : 32'd0;
            cw_reg     <= addr_data.ctl.counter_write;
            cnt_reg    <= addr_data.ctl.counter_write ? addr_data.new_counter : 16'd0;
            crw_reg    <= addr_data.ctl.ccr_write;
            ccr_reg    <= addr_data.ctl.ccr_write ? addr_data.popped_ccr : 5'd0;
            taken_reg  <= addr_data.ctl.taken;
            cycles_reg <= addr_data.ctl.cycles;
        end
    end

    assign done          = done_reg;
    assign new_pc        = pc_reg;
    assign new_sp        = sp_reg;
    assign mem_write     = mw_reg;
    assign write_addr    = waddr_reg;
    assign write_data    = wdata_reg;
    assign new_counter   = cnt_reg;
    assign counter_write = cw_reg;
    assign new_ccr       = ccr_reg;
    assign ccr_write     = crw_reg;
    assign taken         = taken_reg;
    assign cycles        = cycles_reg;

endmodule

[hdl/control_flow_branch_unit.sv]
// top level of the 68000 control flow branch unit
`timescale 1ns / 1ps

// usage
//   command channel: drive the decoded instruction fields and pulse start;
//   a transfer happens at each rising edge with start high and busy low.
//   busy stays low, so a new instruction may be issued every cycle.
//   result channel: done is high for exactly one cycle with all result
//   fields valid; the receiver must take the transfer in that cycle.
// pipeline and throughput
//   three register stages: decode and condition check, target / stack /
//   counter adders, then result selection into the output registers.
//   done rises once the command has passed the decode, adder and output registers in turn.
//   one instruction per cycle sustained; no stage ever holds.
//   the adder stage has one add per path: 32-bit target and stack, 16-bit counter.
// reset
//   rst_n is asynchronous and active low; it clears the stage valid bits,
//   so no result strobe appears after reset until a command is taken.
// stalls
//   the receiver cannot stall, so results leave in command order with
//   no holding or skid storage.

module control_flow_branch_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [3:0]  cond_code,
    input  logic [4:0]  ccr_flags,
    input  logic [31:0] instr_addr,
    input  logic [31:0] next_pc,
    input  logic [31:0] operand,
    input  logic        short_disp,
    input  logic        abs_short,
    input  logic [15:0] counter,
    input  logic [31:0] stack_ptr,
    input  logic [15:0] popped_word,
    input  logic [31:0] popped_long,
    output logic        done,
    output logic [31:0] new_pc,
    output logic [31:0] new_sp,
    output logic        mem_write,
    output logic [31:0] write_addr,
    output logic [31:0] write_data,
    output logic [15:0] new_counter,
    output logic        counter_write,
    output logic [4:0]  new_ccr,
    output logic        ccr_write,
    output logic        taken,
    output logic [4:0]  cycles
);

    logic             accept;
    logic             dec_valid;
    cfbu_pkg::dec_t   dec_data;
    logic             addr_valid;
    cfbu_pkg::addr_t  addr_data;

    // fully pipelined, never holds off a command
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // decode stage
    cfbu_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .cmd         (cmd),
        .cond_code   (cond_code),
        .ccr_flags   (ccr_flags),
        .instr_addr  (instr_addr),
        .next_pc     (next_pc),
        .operand     (operand),
        .short_disp  (short_disp),
        .abs_short   (abs_short),
        .counter     (counter),
        .stack_ptr   (stack_ptr),
        .popped_word (popped_word),
        .popped_long (popped_long),
        .dec_valid   (dec_valid),
        .dec_data    (dec_data)
    );

    // address arithmetic stage
    cfbu_addr u_addr
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .dec_valid  (dec_valid),
        .dec_data   (dec_data),
        .addr_valid (addr_valid),
        .addr_data  (addr_data)
    );

    // output stage
    cfbu_output u_output
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .addr_valid    (addr_valid),
        .addr_data     (addr_data),
        .done          (done),
        .new_pc        (new_pc),
        .new_sp        (new_sp),
        .mem_write     (mem_write),
        .write_addr    (write_addr),
        .write_data    (write_data),
        .new_counter   (new_counter),
        .counter_write (counter_write),
        .new_ccr       (new_ccr),
        .ccr_write     (ccr_write),
        .taken         (taken),
        .cycles        (cycles)
    );

endmodule
